### src/ptc_pkg.sv
// Shared types, constants and helpers for the playback transport control block.
package ptc_pkg;

  localparam int FRAME_BITS_DEF = 25;
  localparam int LEVEL_COUNT    = 11;

  localparam logic [4:0] DIR_MASK = 5'h1e;
  localparam logic [4:0] BTN_MASK = 5'h17;

  localparam logic [1:0] MODE_VOL  = 2'd0;
  localparam logic [1:0] MODE_BRT  = 2'd1;
  localparam logic [1:0] MODE_SEEK = 2'd2;

  localparam int E_BUTTON = 0;
  localparam int E_SELECT = 1;
  localparam int E_RIGHT  = 2;
  localparam int E_LEFT   = 3;
  localparam int E_DOWN   = 4;
  localparam int E_UP     = 5;

  localparam logic REG_OSD_DURATION  = 1'b0;
  localparam logic REG_REWIND_FRAMES = 1'b1;

  localparam logic [7:0]  OSD_DURATION_RST  = 8'd180;
  localparam logic [15:0] REWIND_FRAMES_RST = 16'd601;

  typedef struct packed {
    logic [7:0]  osd_duration;
    logic [15:0] rewind_frames;
  } ptc_cfg_t;

  typedef struct packed {
    logic [4:0] dir_stable;
    logic [4:0] dir_prev;
    logic [4:0] btn_stable;
    logic [4:0] btn_prev;
    logic [5:0] edges;
    logic [4:0] repeat_cnt;
    logic [6:0] seek_step;
    logic [1:0] mode;
    logic [3:0] volume;
    logic [3:0] bright;
    logic       play;
    logic [7:0] timecode;
    logic [7:0] levelbar;
    logic       mono;
    logic [3:0] audio;
  } ptc_state_t;

  localparam ptc_state_t STATE_RST = '{
    dir_stable: 5'd0,
    dir_prev:   5'd0,
    btn_stable: 5'd0,
    btn_prev:   5'd0,
    edges:      6'b000010,
    repeat_cnt: 5'd0,
    seek_step:  7'd1,
    mode:       MODE_SEEK,
    volume:     4'd6,
    bright:     4'd6,
    play:       1'b1,
    timecode:   8'd0,
    levelbar:   8'd0,
    mono:       1'b0,
    audio:      4'd6
  };

  function automatic logic [3:0] level_adjust(input logic [3:0] lvl, input logic down);
    logic [4:0] inc;
    inc = {1'b0, lvl} + 5'd1;
    if (down) begin
      level_adjust = (lvl != 4'd0) ? lvl - 4'd1 : 4'd0;
    end else begin
      level_adjust = (inc >= 5'(LEVEL_COUNT)) ? lvl : inc[3:0];
    end
  endfunction

endpackage

### src/playback_transport_control.sv
// Top level of the playback transport control: input stage, state/result registers, APB port.
//
//   channel | handshake                 | payload
//   --------+---------------------------+------------------------------------------
//   in      | in_valid_i / in_ready_o   | transport_raw_i, sample_direction_i
//   out     | out_valid_o / out_ready_i | frame_number_o .. levelbar_osd_o
//   cfg     | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// One transaction per cycle sustained while out_ready_i is high; out_ready_i low stalls it.
// A transaction passes through the input register, then the step logic, whose result lands in
// the state registers, which also serve as the result register.
// The input stage keeps accepting while a result waits, until both stages are full.
// Reset loads frame 1, playing, seek mode, levels 6 and the default register values.
module playback_transport_control #(
  parameter int FRAME_BITS = ptc_pkg::FRAME_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   transport_raw_i,
  input  logic                         sample_direction_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [FRAME_BITS-1:0] frame_number_o,
  output logic                         playing_o,
  output logic [1:0]                   menu_mode_o,
  output logic [3:0]                   volume_level_o,
  output logic [3:0]                   audio_level_o,
  output logic [3:0]                   bright_level_o,
  output logic                         force_mono_o,
  output logic [7:0]                   timecode_osd_o,
  output logic [7:0]                   levelbar_osd_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ptc_pkg::*;

  ptc_cfg_t                     cfg;
  ptc_state_t                   state_q, state_d;
  logic signed [FRAME_BITS-1:0] frame_q, frame_d;
  logic                         in_vld_q, out_vld_q;
  logic [7:0]                   raw_q;
  logic                         dir_q;
  logic                         advance;

  ptc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ptc_step #(
    .FRAME_BITS (FRAME_BITS)
  ) u_step (
    .state_i    (state_q),
    .frame_i    (frame_q),
    .raw_i      (raw_q),
    .dir_half_i (dir_q),
    .cfg_i      (cfg),
    .state_o    (state_d),
    .frame_o    (frame_d)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      raw_q <= transport_raw_i;
      dir_q <= sample_direction_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      state_q   <= STATE_RST;
      frame_q   <= FRAME_BITS'(1);
    end else begin
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
        frame_q   <= frame_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign frame_number_o = frame_q;
  assign playing_o      = state_q.play;
  assign menu_mode_o    = state_q.mode;
  assign volume_level_o = state_q.volume;
  assign audio_level_o  = state_q.audio;
  assign bright_level_o = state_q.bright;
  assign force_mono_o   = state_q.mono;
  assign timecode_osd_o = state_q.timecode;
  assign levelbar_osd_o = state_q.levelbar;

  a_seek_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.seek_step >= 7'd1 && state_q.seek_step <= 7'd125 && state_q.seek_step[1:0] == 2'b01)
    else $error("seek step out of range");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(raw_q) && $stable(dir_q))
    else $error("input stage lost a stalled transaction");

  a_result_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("result register missed a transaction");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q) && $stable(frame_q))
    else $error("state changed without a transaction");

endmodule

### src/ptc_cfg.sv
// APB register file for the on-screen display duration and rewind distance.
module ptc_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ptc_pkg::ptc_cfg_t   cfg_o
);
  import ptc_pkg::*;

  ptc_cfg_t cfg_q;
  logic     wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.osd_duration  <= OSD_DURATION_RST;
      cfg_q.rewind_frames <= REWIND_FRAMES_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_OSD_DURATION:  cfg_q.osd_duration  <= pwdata[7:0];
        REG_REWIND_FRAMES: cfg_q.rewind_frames <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_OSD_DURATION:  prdata = {24'd0, cfg_q.osd_duration};
      REG_REWIND_FRAMES: prdata = {16'd0, cfg_q.rewind_frames};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

### src/ptc_step.sv
// Next-state logic for one controller sample: debounce, edges, repeat, modes and frame step.
module ptc_step #(
  parameter int FRAME_BITS = ptc_pkg::FRAME_BITS_DEF
) (
  input  ptc_pkg::ptc_state_t            state_i,
  input  logic signed [FRAME_BITS-1:0]   frame_i,
  input  logic [7:0]                     raw_i,
  input  logic                           dir_half_i,
  input  ptc_pkg::ptc_cfg_t              cfg_i,
  output ptc_pkg::ptc_state_t            state_o,
  output logic signed [FRAME_BITS-1:0]   frame_o
);
  import ptc_pkg::*;

  localparam int W = FRAME_BITS + 2;
  localparam logic signed [W-1:0] TOP = {3'b000, {(FRAME_BITS-1){1'b1}}};
  localparam logic signed [W-1:0] BOT = {3'b111, {(FRAME_BITS-1){1'b0}}};
  localparam logic signed [FRAME_BITS-1:0] FRAME_ONE = FRAME_BITS'(1);

  function automatic logic signed [FRAME_BITS-1:0] clamp_frame(input logic signed [W-1:0] v);
    if (v > TOP) begin
      clamp_frame = TOP[FRAME_BITS-1:0];
    end else if (v < BOT) begin
      clamp_frame = BOT[FRAME_BITS-1:0];
    end else begin
      clamp_frame = v[FRAME_BITS-1:0];
    end
  endfunction

  ptc_state_t               s;
  logic signed [FRAME_BITS-1:0] frame;
  logic [4:0]               sample;
  logic                     right, left, up, down, button, select, rst;
  logic [1:0]               last_mode;
  logic signed [8:0]        step;
  logic signed [W-1:0]      sum;

  always_comb begin
    s      = state_i;
    frame  = frame_i;
    sample = 5'd0;
    step   = 9'sd1;
    sum    = '0;

    if (s.timecode != 8'd0) begin
      s.timecode = s.timecode - 8'd1;
    end
    if (s.levelbar != 8'd0) begin
      s.levelbar = s.levelbar - 8'd1;
    end

    if (dir_half_i) begin
      sample = ~raw_i[4:0] & DIR_MASK;
      if (sample == s.dir_prev) begin
        s.dir_stable = sample;
      end
      s.dir_prev = sample;
    end else begin
      sample = ~raw_i[4:0] & BTN_MASK;
      if (sample == s.btn_prev) begin
        s.btn_stable = sample;
      end
      s.btn_prev = sample;
    end

    right  = s.dir_stable[4];
    left   = s.dir_stable[3];
    down   = s.dir_stable[2];
    up     = s.dir_stable[1];
    s.mono = s.btn_stable[4];
    select = s.btn_stable[2];
    rst    = s.btn_stable[1];
    button = s.btn_stable[0];
    last_mode = s.mode;

    if (rst) begin
      frame      = FRAME_ONE;
      s.play     = 1'b1;
      s.timecode = cfg_i.osd_duration;
    end else begin
      if (up && !state_i.edges[E_UP]) begin
        s.mode = (s.mode == MODE_VOL) ? MODE_SEEK : s.mode - 2'd1;
      end else if (down && !state_i.edges[E_DOWN]) begin
        s.mode = (s.mode >= MODE_SEEK) ? MODE_VOL : s.mode + 2'd1;
      end

      if (left || right) begin
        s.repeat_cnt = s.repeat_cnt + 5'd1;
      end else begin
        s.repeat_cnt = 5'd0;
        s.seek_step  = 7'd1;
      end

      if (s.repeat_cnt[4]) begin
        s.repeat_cnt = 5'd0;
        if (left || right) begin
          unique case (s.mode)
            MODE_SEEK: begin
              s.timecode = cfg_i.osd_duration;
              if (s.seek_step < 7'd124) begin
                s.seek_step = s.seek_step + 7'd4;
              end
            end
            MODE_VOL: begin
              s.levelbar = cfg_i.osd_duration;
              s.volume   = level_adjust(s.volume, left);
            end
            MODE_BRT: begin
              s.levelbar = cfg_i.osd_duration;
              s.bright   = level_adjust(s.bright, left);
            end
            default: ;
          endcase
        end
      end

      if (select && !state_i.edges[E_SELECT]) begin
        s.timecode = cfg_i.osd_duration;
        sum   = W'(frame) - $signed({{(W-16){1'b0}}, cfg_i.rewind_frames});
        frame = clamp_frame(sum);
      end else begin
        if (button && !state_i.edges[E_BUTTON]) begin
          s.play = ~s.play;
        end

        if (last_mode != s.mode) begin
          if (s.mode == MODE_SEEK) begin
            s.timecode = cfg_i.osd_duration;
          end else begin
            s.levelbar = cfg_i.osd_duration;
          end
        end

        if (s.levelbar > s.timecode) begin
          s.timecode = 8'd0;
        end else begin
          s.levelbar = 8'd0;
        end

        s.audio = s.play ? s.volume : 4'd0;

        if (!s.play) begin
          priority if (s.mode == MODE_SEEK && right && !state_i.edges[E_RIGHT]) begin
            step = 9'sd2;
          end else if (s.mode == MODE_SEEK && left && !state_i.edges[E_LEFT]) begin
            step = -9'sd2;
          end else begin
            step = frame[0] ? -9'sd1 : 9'sd1;
          end
        end else if (s.mode == MODE_SEEK) begin
          if (right) begin
            step = $signed({2'b00, s.seek_step});
          end else if (left) begin
            step = -$signed({2'b00, s.seek_step});
          end
        end

        sum   = W'(frame) + W'(step);
        frame = clamp_frame(sum);
        if (frame < FRAME_ONE) begin
          frame       = FRAME_ONE;
          s.seek_step = 7'd1;
        end
      end
    end

    s.edges = {up, down, left, right, select, button};
  end

  assign state_o = s;
  assign frame_o = frame;

endmodule

### test/playback_transport_control_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for playback_transport_control: directed table, random controller traffic, APB setup.
module playback_transport_control_test;
  import ptc_pkg::*;

  localparam int FRAME_W = FRAME_BITS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam logic [2:0] OSD_ADDR = {REG_OSD_DURATION, 2'b00};
  localparam logic [2:0] REWIND_ADDR = {REG_REWIND_FRAMES, 2'b00};

  localparam logic [4:0] PAD_RIGHT = 5'h10;
  localparam logic [4:0] PAD_LEFT = 5'h08;
  localparam logic [4:0] PAD_DOWN = 5'h04;
  localparam logic [4:0] PAD_UP = 5'h02;
  localparam logic [4:0] KEY_MONO = 5'h10;
  localparam logic [4:0] KEY_SELECT = 5'h04;
  localparam logic [4:0] KEY_RESET = 5'h02;
  localparam logic [4:0] KEY_PLAY = 5'h01;

  typedef struct packed {
    logic signed [FRAME_W-1:0] frame;
    logic play;
    logic [1:0] mode;
    logic [3:0] volume;
    logic [3:0] audio;
    logic [3:0] bright;
    logic mono;
    logic [7:0] timecode;
    logic [7:0] levelbar;
  } transport_status_t;

  typedef struct {
    logic [7:0] raw;
    logic sdir;
    bit typed;
    transport_status_t status;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] transport_raw_i = 8'hff;
  logic sample_direction_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [FRAME_W-1:0] frame_number_o;
  logic playing_o;
  logic [1:0] menu_mode_o;
  logic [3:0] volume_level_o;
  logic [3:0] audio_level_o;
  logic [3:0] bright_level_o;
  logic force_mono_o;
  logic [7:0] timecode_osd_o;
  logic [7:0] levelbar_osd_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // model state
  logic [7:0] osd_len = OSD_DURATION_RST;
  logic [15:0] rewind_len = REWIND_FRAMES_RST;
  logic [4:0] pad_stable = '0, pad_last = '0, keys_stable = '0, keys_last = '0;
  logic [5:0] held_keys = 6'b000010;
  logic [4:0] repeat_cnt = '0;
  logic [6:0] seek_step = 7'd1;
  logic [1:0] mode_sel = MODE_SEEK;
  logic [3:0] volume_sel = 4'd6, bright_sel = 4'd6, audio_sel = 4'd6;
  logic play_on = 1'b1, mono_on = 1'b0;
  int frame_pos = 1;
  logic [7:0] timecode_left = '0, levelbar_left = '0;

  transport_status_t pending_status[$];
  stim_row_t stim_table[$];
  int mismatches = 0;
  int stall_cycles = 0;
  bit quiet = 1'b0;

  playback_transport_control dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) out_ready_i <= quiet || ($urandom_range(99) >= 6);

  function automatic int clamp_frame(input int v);
    if (v > (1 << (FRAME_W - 1)) - 1) return (1 << (FRAME_W - 1)) - 1;
    if (v < -(1 << (FRAME_W - 1))) return -(1 << (FRAME_W - 1));
    return v;
  endfunction

  function automatic logic [3:0] bump_level(input logic [3:0] lvl, input logic lower);
    if (lower) return (lvl == 0) ? lvl : lvl - 4'd1;
    return (int'(lvl) + 1 >= LEVEL_COUNT) ? lvl : lvl + 4'd1;
  endfunction

  task automatic advance_transport(input logic [7:0] raw, input logic sdir,
                                   output transport_status_t st);
    logic [4:0] bits;
    logic right, left, up, down, play_key, sel, rst;
    logic [1:0] prior_mode;
    bit done;
    int step;
    done = 0;
    if (timecode_left != 0) timecode_left--;
    if (levelbar_left != 0) levelbar_left--;
    if (sdir) begin
      bits = ~raw[4:0] & DIR_MASK;
      if (bits == pad_last) pad_stable = bits;
      pad_last = bits;
    end else begin
      bits = ~raw[4:0] & BTN_MASK;
      if (bits == keys_last) keys_stable = bits;
      keys_last = bits;
    end
    right = |(pad_stable & PAD_RIGHT);
    left = |(pad_stable & PAD_LEFT);
    down = |(pad_stable & PAD_DOWN);
    up = |(pad_stable & PAD_UP);
    mono_on = |(keys_stable & KEY_MONO);
    sel = |(keys_stable & KEY_SELECT);
    rst = |(keys_stable & KEY_RESET);
    play_key = |(keys_stable & KEY_PLAY);

    if (rst) begin
      frame_pos = 1;
      play_on = 1'b1;
      timecode_left = osd_len;
      done = 1;
    end
    if (!done) begin
      prior_mode = mode_sel;
      if (up && !held_keys[E_UP])
        mode_sel = (mode_sel == MODE_VOL) ? MODE_SEEK : mode_sel - 2'd1;
      else if (down && !held_keys[E_DOWN])
        mode_sel = (mode_sel >= MODE_SEEK) ? MODE_VOL : mode_sel + 2'd1;
      if (left || right) begin
        repeat_cnt = repeat_cnt + 5'd1;
      end else begin
        repeat_cnt = '0;
        seek_step = 7'd1;
      end
      if (repeat_cnt[4]) begin
        repeat_cnt = '0;
        if (mode_sel == MODE_SEEK) begin
          timecode_left = osd_len;
          if (seek_step < 7'd124) seek_step += 7'd4;
        end else if (mode_sel == MODE_VOL) begin
          levelbar_left = osd_len;
          volume_sel = bump_level(volume_sel, left);
        end else if (mode_sel == MODE_BRT) begin
          levelbar_left = osd_len;
          bright_sel = bump_level(bright_sel, left);
        end
      end
      if (sel && !held_keys[E_SELECT]) begin
        timecode_left = osd_len;
        frame_pos = clamp_frame(frame_pos - int'(rewind_len));
        done = 1;
      end
    end
    if (!done) begin
      if (play_key && !held_keys[E_BUTTON]) play_on = !play_on;
      if (prior_mode != mode_sel) begin
        if (mode_sel == MODE_SEEK) timecode_left = osd_len;
        else levelbar_left = osd_len;
      end
      if (levelbar_left > timecode_left) timecode_left = '0;
      else levelbar_left = '0;
      audio_sel = play_on ? volume_sel : 4'd0;
      step = 1;
      if (!play_on) begin
        if (mode_sel == MODE_SEEK && right && !held_keys[E_RIGHT]) step = 2;
        else if (mode_sel == MODE_SEEK && left && !held_keys[E_LEFT]) step = -2;
        else step = frame_pos[0] ? -1 : 1;
      end else if (mode_sel == MODE_SEEK) begin
        if (right) step = int'(seek_step);
        else if (left) step = -int'(seek_step);
      end
      frame_pos = clamp_frame(frame_pos + step);
      if (frame_pos < 1) begin
        frame_pos = 1;
        seek_step = 7'd1;
      end
    end
    held_keys = '0;
    held_keys[E_BUTTON] = play_key;
    held_keys[E_SELECT] = sel;
    held_keys[E_RIGHT] = right;
    held_keys[E_LEFT] = left;
    held_keys[E_DOWN] = down;
    held_keys[E_UP] = up;

    st.frame = frame_pos[FRAME_W-1:0];
    st.play = play_on;
    st.mode = mode_sel;
    st.volume = volume_sel;
    st.audio = audio_sel;
    st.bright = bright_sel;
    st.mono = mono_on;
    st.timecode = timecode_left;
    st.levelbar = levelbar_left;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    transport_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_status.size() == 0) begin
        $display("%0t: result with no transaction pending, frame %0d", $time,
                 frame_number_o);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        check_field("frame_number", want.frame, frame_number_o);
        check_field("playing", want.play, playing_o);
        check_field("menu_mode", want.mode, menu_mode_o);
        check_field("volume_level", want.volume, volume_level_o);
        check_field("audio_level", want.audio, audio_level_o);
        check_field("bright_level", want.bright, bright_level_o);
        check_field("force_mono", want.mono, force_mono_o);
        check_field("timecode_osd", want.timecode, timecode_osd_o);
        check_field("levelbar_osd", want.levelbar, levelbar_osd_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [7:0] raw, input logic sdir, input bit typed,
                           input transport_status_t given);
    transport_status_t pred;
    in_valid_i <= 1'b1;
    transport_raw_i <= raw;
    sample_direction_i <= sdir;
    do @(posedge clk_i); while (!in_ready_o);
    advance_transport(raw, sdir, pred);
    pending_status.push_back(typed ? given : pred);
    if (!quiet && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == OSD_ADDR) osd_len = data[7:0];
    else rewind_len = data[15:0];
    @(posedge clk_i);
  endtask

  task automatic add_row(input logic [7:0] raw, input logic sdir);
    stim_table.push_back('{raw: raw, sdir: sdir, typed: 1'b0, status: '0});
  endtask

  // rows whose result follows straight from reset values
  task automatic add_typed(input logic [7:0] raw, input logic sdir, input int frame,
                           input logic [7:0] timecode, input logic mono);
    transport_status_t st;
    st = '{frame: frame[FRAME_W-1:0], play: 1'b1, mode: MODE_SEEK, volume: 4'd6,
           audio: 4'd6, bright: 4'd6, mono: mono, timecode: timecode, levelbar: 8'd0};
    stim_table.push_back('{raw: raw, sdir: sdir, typed: 1'b1, status: st});
  endtask

  function automatic logic [7:0] to_raw(input logic [4:0] keys, input logic [4:0] mask);
    logic [7:0] r;
    r = 8'($urandom);
    r[4:0] = (r[4:0] & ~mask) | (~keys & mask);
    return r;
  endfunction

  function automatic logic [4:0] pick_pad();
    case ($urandom_range(9))
      0, 1, 2: return PAD_RIGHT;
      3, 4, 5: return PAD_LEFT;
      6: return PAD_UP;
      7: return PAD_DOWN;
      8: return 5'h00;
      default: return 5'($urandom) & DIR_MASK;
    endcase
  endfunction

  function automatic logic [4:0] pick_keys();
    int roll;
    roll = $urandom_range(19);
    if (roll < 12) return 5'h00;
    if (roll < 14) return KEY_PLAY;
    if (roll < 16) return KEY_MONO;
    if (roll < 18) return KEY_SELECT;
    if (roll < 19) return KEY_RESET;
    return 5'($urandom) & BTN_MASK;
  endfunction

  task automatic run_random(input int count);
    int sent, len, kind;
    logic [4:0] pad, keys;
    logic sdir;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        send_item(8'($urandom), 1'($urandom), 1'b0, '0);
        sent++;
      end else begin
        pad = pick_pad();
        keys = pick_keys();
        len = $urandom_range(2, 40);
        kind = $urandom_range(3);
        for (int i = 0; i < len; i++) begin
          sdir = (kind == 0) ? 1'b1 : (kind == 1) ? 1'b0 : i[0];
          send_item(sdir ? to_raw(pad, DIR_MASK) : to_raw(keys, BTN_MASK), sdir, 1'b0, '0);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    add_typed(8'hff, 1'b1, 2, 8'd0, 1'b0);
    add_row(8'hfd, 1'b0);
    add_typed(8'hfd, 1'b0, 1, 8'd180, 1'b0);
    add_typed(8'h00, 1'b0, 1, 8'd180, 1'b0);
    add_typed(8'h00, 1'b0, 1, 8'd180, 1'b1);
    add_row(8'hff, 1'b0);
    add_row(8'hff, 1'b0);
    add_row(8'hfb, 1'b0);
    add_row(8'hfb, 1'b0);
    add_row(8'hff, 1'b0);
    add_row(8'hff, 1'b0);
    add_row(8'hfe, 1'b0);
    add_row(8'hfe, 1'b0);
    add_row(8'hff, 1'b0);
    add_row(8'hff, 1'b0);
    add_row(8'hfb, 1'b1);
    add_row(8'hfb, 1'b1);
    add_row(8'hff, 1'b1);
    add_row(8'hff, 1'b1);
    add_row(8'hfd, 1'b1);
    add_row(8'hfd, 1'b1);
    add_row(8'hf7, 1'b1);
    add_row(8'hf7, 1'b1);
    add_row(8'hef, 1'b1);
    add_row(8'hef, 1'b1);
    add_row(8'h00, 1'b1);
    add_row(8'hff, 1'b1);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i])
      send_item(stim_table[i].raw, stim_table[i].sdir, stim_table[i].typed,
                stim_table[i].status);

    drain_results();
    reg_write(OSD_ADDR, 32'd255);
    reg_write(REWIND_ADDR, 32'd65535);
    run_random(270);

    drain_results();
    reg_write(OSD_ADDR, 32'd1);
    reg_write(REWIND_ADDR, 32'd0);
    quiet = 1'b1;
    run_random(270);
    quiet = 1'b0;

    drain_results();
    reg_write(OSD_ADDR, 32'($urandom_range(1, 255)));
    reg_write(REWIND_ADDR, 32'($urandom_range(0, 65535)));
    run_random(260);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
src/ptc_pkg.sv
src/ptc_cfg.sv
src/ptc_step.sv
src/playback_transport_control.sv
test/playback_transport_control_test.sv
